/* rtl/core/intt_pkg.sv */
`default_nettype none

package intt_pkg;

    localparam int unsigned POINTS    = 1024;
    localparam int unsigned IDX_W     = 10;
    localparam int unsigned DATA_W    = 32;

    localparam logic [30:0] MODULUS_RST = 31'd33550337;
    localparam logic [63:0] PINV_RST    = 64'd5764325841882320897;
    localparam logic [31:0] HALF_RST    = 32'd16773122;

    typedef enum logic [1:0] {
        CMD_LOAD_COEF = 2'd0,
        CMD_LOAD_TW   = 2'd1,
        CMD_RUN       = 2'd2,
        CMD_READ      = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        REG_MODULUS = 2'd0,
        REG_PINV    = 2'd1,
        REG_HALF    = 2'd2
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TWRD,
        ST_CFRD,
        ST_CALC,
        ST_WRBK,
        ST_READ
    } state_t;

    function automatic logic [7:0] rev8(input logic [7:0] k);
        logic [7:0] r;
        for (int b = 0; b < 8; b++)
        begin
            r[7-b] = k[b];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/inverse_ntt_plantard_1024.sv */
`default_nettype none

// Inverse 1024-point NTT with Plantard reduction. Requests carry a command:
// load coefficient, load twiddle, run the transform in place, or read one
// coefficient back. A load is written at the edge that accepts it; a read
// passes through the registered memory output and then the read_value
// register. A run takes 5 passes of 256 merged radix-4 butterflies; each
// butterfly reads the coefficient memory, computes twelve Plantard products on
// one shared 33x33 multiplier, and writes back, and each of the 341 twiddle
// blocks first reads the twiddle memory. Both stores are single memories with
// one read and one write port; requests stall during a run and while a read
// result waits.
module inverse_ntt_plantard_1024 (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [1:0]                    cmd,
    input  wire logic [intt_pkg::IDX_W-1:0]    entry_index,
    input  wire logic signed [31:0]            entry_value,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [intt_pkg::IDX_W-1:0]         read_index,
    output logic signed [31:0]                 read_value,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [4:0]                    paddr,
    input  wire logic [63:0]                   pwdata,
    output logic [63:0]                        prdata,
    output logic                               pready
);
    import intt_pkg::*;

    logic [31:0] cf_mem [POINTS];
    logic [31:0] tw_mem [POINTS];

    state_t      state_reg, state_next;
    logic [2:0]  pass_reg, pass_next;
    logic [7:0]  bc_reg, bc_next;
    logic [2:0]  sub_reg, sub_next;
    logic [3:0]  op_reg, op_next;
    logic [2:0]  step_reg, step_next;
    logic [31:0] r_reg [4];
    logic [31:0] r_next [4];
    logic [31:0] w_reg [3];
    logic [31:0] w_next [3];
    logic [63:0] prod_reg, prod_next;
    logic [31:0] acc_reg, acc_next;
    logic        out_valid_reg, out_valid_next;
    logic [IDX_W-1:0] read_index_reg, read_index_next;
    logic [31:0] read_value_reg, read_value_next;
    logic [30:0] modulus_reg;
    logic [63:0] pinv_reg;
    logic [31:0] half_reg;

    logic             cf_we, tw_we;
    logic [IDX_W-1:0] cf_waddr, cf_raddr, tw_raddr;
    logic [31:0]      cf_wdata;
    logic [31:0]      cf_q, tw_q;

    logic        in_acc;
    logic [8:0]  d9;
    logic [7:0]  imask, ioff, jpart, kpow;
    logic [8:0]  pw;
    logic [16:0] dp17;
    logic [IDX_W-1:0] dp, s0;
    logic [IDX_W-1:0] kaddr [4];
    logic [IDX_W-1:0] twaddr [3];
    logic [7:0]  bc_inc;
    logic        last_bfly;

    logic [1:0]  tgt;
    logic [31:0] op_a, op_b, res;
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;
    logic [31:0] r_new [4];

    assign in_stall   = (state_reg != ST_IDLE) || out_valid_reg;
    assign in_acc     = in_valid && !in_stall;
    assign out_valid  = out_valid_reg;
    assign read_index = read_index_reg;
    assign read_value = read_value_reg;
    assign pready     = 1'b1;

    always_comb
    begin
        case (reg_idx_t'(paddr[4:3]))
            REG_MODULUS: prdata = {33'd0, modulus_reg};
            REG_PINV:    prdata = pinv_reg;
            REG_HALF:    prdata = {32'd0, half_reg};
            default:     prdata = 64'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= MODULUS_RST;
            pinv_reg    <= PINV_RST;
            half_reg    <= HALF_RST;
        end
        else if (psel && penable && pwrite)
        begin
            case (reg_idx_t'(paddr[4:3]))
                REG_MODULUS: modulus_reg <= pwdata[30:0];
                REG_PINV:    pinv_reg    <= pwdata;
                REG_HALF:    half_reg    <= pwdata[31:0];
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cf_we)
        begin
            cf_mem[cf_waddr] <= cf_wdata;
        end
        cf_q <= cf_mem[cf_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (tw_we)
        begin
            tw_mem[entry_index] <= entry_value;
        end
        tw_q <= tw_mem[tw_raddr];
    end

    // butterfly addressing and twiddle indices
    always_comb
    begin
        d9       = 9'(9'd1 << {pass_reg, 1'b0});
        imask    = 8'(d9 - 9'd1);
        ioff     = bc_reg & imask;
        jpart    = bc_reg & ~imask;
        s0       = IDX_W'(ioff) + {jpart, 2'b00};
        kaddr[0] = s0;
        kaddr[1] = s0 + IDX_W'(d9);
        kaddr[2] = s0 + IDX_W'({d9, 1'b0});
        kaddr[3] = s0 + IDX_W'(d9) + IDX_W'({d9, 1'b0});
        kpow     = 8'(9'd256 - d9 - {1'b0, jpart});
        pw       = {rev8(kpow), 1'b1};
        dp17     = 17'({8'd0, pw} << {pass_reg, 1'b0});
        dp       = dp17[IDX_W-1:0];
        twaddr[0] = {dp[IDX_W-2:0], 1'b0};
        twaddr[1] = {~dp[IDX_W-1], dp[IDX_W-2:0]};
        twaddr[2] = dp;
        bc_inc    = bc_reg + 8'd1;
        last_bfly = (bc_reg == 8'd255);
    end

    // Plantard product sequencing
    always_comb
    begin
        case (op_reg)
            4'd0:    tgt = 2'd1;
            4'd1:    tgt = 2'd3;
            4'd2:    tgt = 2'd0;
            4'd3:    tgt = 2'd1;
            4'd4:    tgt = 2'd2;
            4'd5:    tgt = 2'd3;
            4'd6:    tgt = 2'd2;
            4'd7:    tgt = 2'd3;
            4'd8:    tgt = 2'd0;
            4'd9:    tgt = 2'd1;
            4'd10:   tgt = 2'd2;
            4'd11:   tgt = 2'd3;
            default: tgt = 2'd0;
        endcase
        case (op_reg)
            4'd0:    op_b = w_reg[1];
            4'd1:    op_b = w_reg[2];
            4'd6:    op_b = w_reg[0];
            4'd7:    op_b = w_reg[0];
            default: op_b = half_reg;
        endcase
        op_a = r_reg[tgt];
        case (step_reg)
            3'd0:
            begin
                mul_a = {op_a[31], op_a};
                mul_b = {op_b[31], op_b};
            end
            3'd1:
            begin
                mul_a = {1'b0, prod_reg[31:0]};
                mul_b = {1'b0, pinv_reg[31:0]};
            end
            3'd2:
            begin
                mul_a = {1'b0, prod_reg[31:0]};
                mul_b = {1'b0, pinv_reg[63:32]};
            end
            3'd3:
            begin
                mul_a = {1'b0, prod_reg[63:32]};
                mul_b = {1'b0, pinv_reg[31:0]};
            end
            default:
            begin
                mul_a = {acc_reg[31], acc_reg};
                mul_b = {2'b00, modulus_reg};
            end
        endcase
        mul_p = mul_a * mul_b;
        res   = mul_p[63:32];
        for (int n = 0; n < 4; n++)
        begin
            r_new[n] = (2'(n) == tgt) ? res : r_reg[n];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && cmd_t'(cmd) == CMD_RUN)
                begin
                    state_next = ST_TWRD;
                end
                else if (in_acc && cmd_t'(cmd) == CMD_READ)
                begin
                    state_next = ST_READ;
                end
            end
            ST_TWRD:
            begin
                if (sub_reg == 3'd3)
                begin
                    state_next = ST_CFRD;
                end
            end
            ST_CFRD:
            begin
                if (sub_reg == 3'd4)
                begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                if (op_reg == 4'd11 && step_reg == 3'd4)
                begin
                    state_next = ST_WRBK;
                end
            end
            ST_WRBK:
            begin
                if (sub_reg == 3'd3)
                begin
                    if (last_bfly && pass_reg == 3'd4)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (last_bfly || (bc_inc & imask) == 8'd0)
                    begin
                        state_next = ST_TWRD;
                    end
                    else
                    begin
                        state_next = ST_CFRD;
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pass_next       = pass_reg;
        bc_next         = bc_reg;
        sub_next        = sub_reg;
        op_next         = op_reg;
        step_next       = step_reg;
        r_next          = r_reg;
        w_next          = w_reg;
        prod_next       = prod_reg;
        acc_next        = acc_reg;
        out_valid_next  = out_valid_reg && out_stall;
        read_index_next = read_index_reg;
        read_value_next = read_value_reg;
        cf_we           = 1'b0;
        tw_we           = 1'b0;
        cf_waddr        = entry_index;
        cf_wdata        = entry_value;
        cf_raddr        = entry_index;
        tw_raddr        = entry_index;
        case (state_reg)
            ST_IDLE:
            begin
                pass_next = 3'd0;
                bc_next   = 8'd0;
                sub_next  = 3'd0;
                if (in_acc)
                begin
                    cf_we           = (cmd_t'(cmd) == CMD_LOAD_COEF);
                    tw_we           = (cmd_t'(cmd) == CMD_LOAD_TW);
                    read_index_next = entry_index;
                end
            end
            ST_TWRD:
            begin
                tw_raddr = twaddr[(sub_reg == 3'd3) ? 2'd2 : sub_reg[1:0]];
                if (sub_reg != 3'd0)
                begin
                    w_next[sub_reg[1:0] - 2'd1] = 32'd0 - tw_q;
                end
                sub_next = (sub_reg == 3'd3) ? 3'd0 : sub_reg + 3'd1;
            end
            ST_CFRD:
            begin
                cf_raddr = kaddr[sub_reg[1:0]];
                if (sub_reg == 3'd4)
                begin
                    r_next[0] = r_reg[0] + r_reg[1];
                    r_next[1] = r_reg[0] - r_reg[1];
                    r_next[2] = r_reg[2] + cf_q;
                    r_next[3] = r_reg[2] - cf_q;
                    sub_next  = 3'd0;
                    op_next   = 4'd0;
                    step_next = 3'd0;
                end
                else
                begin
                    if (sub_reg != 3'd0)
                    begin
                        r_next[sub_reg[1:0] - 2'd1] = cf_q;
                    end
                    sub_next = sub_reg + 3'd1;
                end
            end
            ST_CALC:
            begin
                case (step_reg)
                    3'd0: prod_next = mul_p[63:0];
                    3'd1: acc_next  = mul_p[63:32];
                    3'd2: acc_next  = acc_reg + mul_p[31:0];
                    3'd3: acc_next  = acc_reg + mul_p[31:0] + 32'd16;
                    default:
                    begin
                        r_next = r_new;
                        if (op_reg == 4'd5)
                        begin
                            r_next[0] = r_new[0] + r_new[2];
                            r_next[1] = r_new[1] + r_new[3];
                            r_next[2] = r_new[0] - r_new[2];
                            r_next[3] = r_new[1] - r_new[3];
                        end
                    end
                endcase
                if (step_reg == 3'd4)
                begin
                    step_next = 3'd0;
                    op_next   = op_reg + 4'd1;
                    sub_next  = 3'd0;
                end
                else
                begin
                    step_next = step_reg + 3'd1;
                end
            end
            ST_WRBK:
            begin
                cf_we    = 1'b1;
                cf_waddr = kaddr[sub_reg[1:0]];
                cf_wdata = r_reg[sub_reg[1:0]];
                if (sub_reg == 3'd3)
                begin
                    sub_next = 3'd0;
                    bc_next  = bc_inc;
                    if (last_bfly)
                    begin
                        pass_next = pass_reg + 3'd1;
                    end
                end
                else
                begin
                    sub_next = sub_reg + 3'd1;
                end
            end
            ST_READ:
            begin
                out_valid_next  = 1'b1;
                read_value_next = cf_q;
            end
            default:
            begin
                sub_next = 3'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pass_reg      <= 3'd0;
            bc_reg        <= 8'd0;
            sub_reg       <= 3'd0;
            op_reg        <= 4'd0;
            step_reg      <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pass_reg      <= pass_next;
            bc_reg        <= bc_next;
            sub_reg       <= sub_next;
            op_reg        <= op_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg          <= r_next;
        w_reg          <= w_next;
        prod_reg       <= prod_next;
        acc_reg        <= acc_next;
        read_index_reg <= read_index_next;
        read_value_reg <= read_value_next;
    end

endmodule

`default_nettype wire

/* verif/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import intt_pkg::*;

    typedef struct packed {
        cmd_t        op;
        logic [9:0]  idx;
        logic [31:0] val;
    } request_t;

    typedef struct packed {
        logic [9:0]  idx;
        logic [31:0] val;
    } coef_read_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    cmd_t        cmd;
    logic [9:0]  entry_index;
    logic [31:0] entry_value;
    logic        out_valid;
    logic        out_stall;
    logic [9:0]  read_index;
    logic [31:0] read_value;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    request_t   request_q[$];
    coef_read_t read_q[$];

    logic [31:0] coef_mem[1024];
    logic [31:0] tw_mem[1024];
    logic [30:0] cur_modulus;
    logic [63:0] cur_pinv;
    logic [31:0] cur_half;

    request_t cur_req;
    bit       req_busy;
    bit       req_taken;
    int       gap_cnt;
    int       stall_cnt;
    int       long_hold;
    bit       no_idle;
    int       mismatches;

    inverse_ntt_plantard_1024 u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .entry_index (entry_index),
        .entry_value (entry_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .read_index  (read_index),
        .read_value  (read_value),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic logic [31:0] plantard_mul(logic [31:0] a, logic [31:0] b);
        longint      prod;
        logic [63:0] u;
        logic [31:0] e;
        longint      t;
        prod = longint'($signed(a)) * longint'($signed(b));
        u = 64'(prod) * cur_pinv;
        e = u[63:32] + 32'd16;
        t = longint'($signed(e)) * longint'({33'b0, cur_modulus});
        return t[63:32];
    endfunction

    function automatic int unsigned odd_power(int unsigned k);
        int unsigned r;
        r = 0;
        for (int b = 0; b < 8; b++)
        begin
            r |= ((k >> b) & 1) << (7 - b);
        end
        return 2 * r + 1;
    endfunction

    function automatic void butterfly(int unsigned s, int unsigned d,
                                      logic [31:0] w1, logic [31:0] w2, logic [31:0] w3);
        int unsigned k0, k1, k2, k3;
        logic [31:0] a, b, c, e, x0, x1, x2, x3;
        k0 = s & 1023;
        k1 = (s + d) & 1023;
        k2 = (s + 2 * d) & 1023;
        k3 = (s + 3 * d) & 1023;
        a = coef_mem[k0];
        b = coef_mem[k1];
        c = coef_mem[k2];
        e = coef_mem[k3];
        x0 = a + b;
        x1 = a - b;
        x2 = c + e;
        x3 = c - e;
        x1 = plantard_mul(x1, 32'd0 - w2);
        x3 = plantard_mul(x3, 32'd0 - w3);
        x0 = plantard_mul(x0, cur_half);
        x1 = plantard_mul(x1, cur_half);
        x2 = plantard_mul(x2, cur_half);
        x3 = plantard_mul(x3, cur_half);
        a = x0 + x2;
        b = x1 + x3;
        c = x0 - x2;
        e = x1 - x3;
        c = plantard_mul(c, 32'd0 - w1);
        e = plantard_mul(e, 32'd0 - w1);
        coef_mem[k0] = plantard_mul(a, cur_half);
        coef_mem[k1] = plantard_mul(b, cur_half);
        coef_mem[k2] = plantard_mul(c, cur_half);
        coef_mem[k3] = plantard_mul(e, cur_half);
    endfunction

    function automatic void inverse_transform();
        int unsigned blocks, p;
        for (int unsigned d = 1; d <= 256; d *= 4)
        begin
            blocks = 256 / d;
            for (int unsigned j = 0; j < blocks; j++)
            begin
                p = odd_power(d * (blocks - 1 - j));
                for (int unsigned i = 0; i < d; i++)
                begin
                    butterfly(i + 4 * d * j, d, tw_mem[(2 * d * p) & 1023],
                              tw_mem[(d * p + 512) & 1023], tw_mem[(d * p) & 1023]);
                end
            end
        end
    endfunction

    function automatic void apply_request(request_t r);
        case (r.op)
            CMD_LOAD_COEF: coef_mem[r.idx] = r.val;
            CMD_LOAD_TW:   tw_mem[r.idx] = r.val;
            CMD_RUN:       inverse_transform();
            default:       read_q.push_back('{r.idx, coef_mem[r.idx]});
        endcase
    endfunction

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0;
            3:       return 32'hffff_ffff;
            4:       return 32'($urandom_range(0, 33550336));
            default: return $urandom;
        endcase
    endfunction

    function automatic void push(cmd_t op, int unsigned idx, logic [31:0] val);
        request_q.push_back('{op, 10'(idx), val});
    endfunction

    // request accept and predict
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            apply_request(cur_req);
            req_taken = 1'b1;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (req_taken)
            begin
                req_taken = 1'b0;
                req_busy = 1'b0;
                gap_cnt = no_idle ? 0 : $urandom_range(0, 9);
            end
            if (!req_busy)
            begin
                if (gap_cnt > 0)
                begin
                    gap_cnt--;
                end
                else if (request_q.size() > 0)
                begin
                    cur_req = request_q.pop_front();
                    req_busy = 1'b1;
                    cmd <= cur_req.op;
                    entry_index <= cur_req.idx;
                    entry_value <= cur_req.val;
                end
            end
            in_valid <= req_busy;
        end
    end

    always @(negedge clk)
    begin
        if (long_hold > 0)
        begin
            long_hold--;
            out_stall <= 1'b1;
        end
        else if (stall_cnt > 0)
        begin
            stall_cnt--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        coef_read_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (read_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected result: index %0d value %h", read_index, read_value);
                end
            end
            else
            begin
                want = read_q.pop_front();
                if (read_index !== want.idx || read_value !== want.val)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch: expected index %0d value %h, got index %0d value %h",
                                 want.idx, want.val, read_index, read_value);
                    end
                end
            end
            stall_cnt = no_idle ? 0 : $urandom_range(0, 9);
        end
    end

    task automatic reg_write(reg_idx_t r, logic [63:0] value);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= 5'(r) << 3;
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (r)
            REG_MODULUS: cur_modulus = value[30:0];
            REG_PINV:    cur_pinv = value;
            default:     cur_half = value[31:0];
        endcase
    endtask

    task automatic drain();
        while (request_q.size() > 0 || req_busy || read_q.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
    endtask

    task automatic random_phase(int n);
        int unsigned sel;
        for (int k = 0; k < n; k++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 40)
                push(CMD_LOAD_COEF, $urandom_range(0, 1023), rand_value());
            else if (sel < 55)
                push(CMD_LOAD_TW, $urandom_range(0, 1023), rand_value());
            else
                push(CMD_READ, $urandom_range(0, 1023), rand_value());
            if (k == n / 2)
                push(CMD_RUN, $urandom_range(0, 1023), rand_value());
        end
        push(CMD_READ, $urandom_range(0, 1023), rand_value());
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        cmd = CMD_LOAD_COEF;
        entry_index = '0;
        entry_value = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        req_busy = 1'b0;
        req_taken = 1'b0;
        gap_cnt = 0;
        stall_cnt = 0;
        long_hold = 0;
        no_idle = 1'b0;
        mismatches = 0;
        cur_modulus = MODULUS_RST;
        cur_pinv = PINV_RST;
        cur_half = HALF_RST;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // fill both stores so no unwritten entry is ever read
        push(CMD_LOAD_COEF, 0, 32'h8000_0000);
        push(CMD_LOAD_COEF, 1, 32'h7fff_ffff);
        push(CMD_LOAD_COEF, 2, 32'h0);
        push(CMD_LOAD_COEF, 3, 32'hffff_ffff);
        for (int i = 4; i < 1024; i++)
            push(CMD_LOAD_COEF, i, rand_value());
        for (int i = 0; i < 1024; i++)
            push(CMD_LOAD_TW, i, rand_value());
        push(CMD_READ, 0, 32'h0);
        push(CMD_READ, 1023, 32'hffff_ffff);
        push(CMD_READ, 1, 32'h0);
        push(CMD_RUN, 1023, 32'h7fff_ffff);
        push(CMD_READ, 0, 32'h0);
        push(CMD_READ, 512, 32'h0);
        push(CMD_READ, 1023, 32'h0);
        drain();

        reg_write(REG_MODULUS, 64'd3);
        reg_write(REG_PINV, 64'h8000_0000_0000_0000);
        reg_write(REG_HALF, 64'h0000_0000_8000_0000);
        no_idle = 1'b1;
        random_phase(80);
        drain();

        reg_write(REG_MODULUS, 64'd2147483647);
        reg_write(REG_PINV, 64'h7fff_ffff_ffff_ffff);
        reg_write(REG_HALF, 64'h0000_0000_7fff_ffff);
        no_idle = 1'b0;
        // hold off the receiver while reads pile up
        long_hold = 400;
        for (int k = 0; k < 30; k++)
            push(CMD_READ, $urandom_range(0, 1023), rand_value());
        random_phase(80);
        drain();

        reg_write(REG_MODULUS, {33'b0, 31'($urandom_range(3, 32'h7fff_ffff))});
        reg_write(REG_PINV, {$urandom, $urandom});
        reg_write(REG_HALF, {32'b0, $urandom});
        random_phase(80);
        drain();

        reg_write(REG_MODULUS, {33'b0, MODULUS_RST});
        reg_write(REG_PINV, PINV_RST);
        reg_write(REG_HALF, {32'b0, HALF_RST});
        random_phase(120);
        drain();

        if (mismatches == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial
    begin
        #60_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
